FILE: rtl/six_port_timer_registers_top_assert.svh
// assertion macros shared by the timer register block
`ifndef SIX_PORT_TIMER_REGISTERS_TOP_ASSERT_SVH
`define SIX_PORT_TIMER_REGISTERS_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on the rising clock edge
`define SPT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on the rising clock edge
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPT_ASSERT_IMPL(label, ante, cons, msg)
`define SPT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/spt_pkg.sv
// types and constants of the timer register block
`timescale 1ns / 1ps

package spt_pkg;

    // item kinds
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register numbers with a meaning of their own
    localparam logic [2:0] REG_CTRL13 = 3'd0;
    localparam logic [2:0] REG_CTRL2  = 3'd1;

    localparam logic [7:0]  STATUS_BYTE   = 8'h87;
    localparam logic [2:0]  DIVIDE_BY     = 3'd5;
    localparam logic [15:0] COUNTER_RESET = 16'hFFFF;

    // one input beat
    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_byte;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [7:0] read_byte;
        logic       timer_irq;
        logic       frame_pulse;
    } result_t;

endpackage

FILE: rtl/spt_in_stage.sv
// input register of the timer register block
`timescale 1ns / 1ps

module spt_in_stage
    import spt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_byte,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // the register takes a new beat when empty or when its beat moves on
    assign load       = !valid_reg || advance;
    assign valid_next = load ? in_valid : valid_reg;
    assign in_stall   = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= '{opcode: opcode, reg_index: reg_index, write_byte: write_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/spt_core.sv
// counters, control state and per-beat result logic
`timescale 1ns / 1ps

module spt_core
    import spt_pkg::*;
#(
    parameter int NUM_COUNTERS = 3
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

`include "six_port_timer_registers_top_assert.svh"

    localparam int CIDX_W = $clog2(NUM_COUNTERS);
    localparam logic [CIDX_W-1:0] TIMER_IDX = CIDX_W'(NUM_COUNTERS - 1);

    logic [15:0] cnt_reg [NUM_COUNTERS];
    logic [15:0] cnt_next [NUM_COUNTERS];
    logic        sel_reg;
    logic        sel_next;
    logic        pending_reg;
    logic        pending_next;
    logic        armed_reg;
    logic        armed_next;
    logic [2:0]  div_count_reg;
    logic [2:0]  div_count_next;

    logic [CIDX_W-1:0] cidx;
    logic [15:0]       cnt_sel;
    logic [15:0]       timer_cnt;
    logic [2:0]        div_inc;
    logic              pulse;
    logic [7:0]        rd;

    // counter addressed by register pairs two and up
    assign cidx      = CIDX_W'(item.reg_index[2:1]) - CIDX_W'(1);
    assign cnt_sel   = cnt_reg[cidx];
    assign timer_cnt = cnt_reg[TIMER_IDX];

    // read data
    always_comb
    begin
        rd = 8'd0;
        if (item.opcode == OP_READ)
        begin
            unique case (item.reg_index)
                REG_CTRL13: rd = 8'd0;
                REG_CTRL2:  rd = STATUS_BYTE;
                default:    rd = item.reg_index[0] ? cnt_sel[7:0] : cnt_sel[15:8];
            endcase
        end
    end

    // next state for writes and ticks
    always_comb
    begin
        for (int k = 0; k < NUM_COUNTERS; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        sel_next       = sel_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        div_count_next = div_count_reg;
        div_inc        = div_count_reg + 3'd1;
        pulse          = 1'b0;

        if (fire)
        begin
            unique case (item.opcode)
                OP_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_CTRL13:
                        begin
                            // internal reset only through control 1
                            if (sel_reg && item.write_byte[0])
                            begin
                                for (int k = 0; k < NUM_COUNTERS; k++)
                                begin
                                    cnt_next[k] = COUNTER_RESET;
                                end
                                pending_next = 1'b0;
                            end
                        end
                        REG_CTRL2:
                        begin
                            sel_next = item.write_byte[0];
                        end
                        default:
                        begin
                            if (item.reg_index[0])
                            begin
                                cnt_next[cidx] = {cnt_sel[15:8], item.write_byte};
                            end
                            else
                            begin
                                cnt_next[cidx] = {item.write_byte, cnt_sel[7:0]};
                                if (cidx == TIMER_IDX)
                                begin
                                    pending_next = 1'b0;
                                end
                            end
                        end
                    endcase
                end
                OP_TICK:
                begin
                    // counter three counts down and wraps on underflow
                    if (timer_cnt == 16'd0)
                    begin
                        cnt_next[TIMER_IDX] = COUNTER_RESET;
                        pending_next        = 1'b1;
                        armed_next          = 1'b1;
                    end
                    else
                    begin
                        cnt_next[TIMER_IDX] = timer_cnt - 16'd1;
                    end
                    // divide-by-five once armed
                    if (armed_next)
                    begin
                        if (div_inc >= DIVIDE_BY)
                        begin
                            div_count_next = 3'd0;
                            pulse          = 1'b1;
                        end
                        else
                        begin
                            div_count_next = div_inc;
                        end
                    end
                end
                default:
                begin
                    // reads and the unused code leave state alone
                end
            endcase
        end
    end

    // result of the beat in the input register
    assign result.read_byte   = rd;
    assign result.timer_irq   = (item.opcode == OP_TICK) && pending_next;
    assign result.frame_pulse = (item.opcode == OP_TICK) && pulse;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COUNTERS; k++)
            begin
                cnt_reg[k] <= COUNTER_RESET;
            end
            sel_reg       <= 1'b0;
            pending_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            div_count_reg <= 3'd0;
        end
        else
        begin
            for (int k = 0; k < NUM_COUNTERS; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            sel_reg       <= sel_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
            div_count_reg <= div_count_next;
        end
    end

    // checks
    `SPT_ASSERT_IMPL(a_pulse_on_tick, result.frame_pulse, item.opcode == OP_TICK, "pulse without tick")
    `SPT_ASSERT_NEXT(a_armed_sticky, armed_reg, armed_reg, "divider disarmed")
    `SPT_ASSERT_IMPL(a_idle_divider, !armed_reg, div_count_reg == 3'd0, "divider counted unarmed")
    `SPT_ASSERT_NEXT(a_underflow_pending, fire && item.opcode == OP_TICK && timer_cnt == 16'd0, pending_reg && armed_reg, "underflow not recorded")

endmodule

FILE: rtl/spt_out_stage.sv
// result register of the timer register block
`timescale 1ns / 1ps

module spt_out_stage
    import spt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  result_t    result,
    output logic       advance,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_byte,
    output logic       timer_irq,
    output logic       frame_pulse
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // the register moves on when empty or when its beat is taken
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = valid_reg;
    assign read_byte   = result_reg.read_byte;
    assign timer_irq   = result_reg.timer_irq;
    assign frame_pulse = result_reg.frame_pulse;

endmodule

FILE: rtl/six_port_timer_registers_top.sv
// top level of the three-counter timer register block
`timescale 1ns / 1ps

// Three 16-bit counters behind eight byte registers. Each input beat is a bus
// read, a bus write or one tick of counter three, and gives exactly one result
// beat. A beat can be accepted every clock cycle while the result side does
// not stall. All counter and control updates are worked out while the beat
// is in the input register, and its result is registered in the result
// register, from which the receiver takes it.
// A stall on the result side holds the result register and, in the same
// cycle, a beat held in the input register, so no beat is lost or repeated.

module six_port_timer_registers_top
    import spt_pkg::*;
#(
    parameter int NUM_COUNTERS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [2:0] reg_index,
    input  logic [7:0] write_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_byte,
    output logic       timer_irq,
    output logic       frame_pulse
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;

    // input register
    spt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .reg_index  (reg_index),
        .write_byte (write_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // counters and result logic
    spt_core #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_valid && advance),
        .item   (item),
        .result (result)
    );

    // result register
    spt_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .result      (result),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_byte   (read_byte),
        .timer_irq   (timer_irq),
        .frame_pulse (frame_pulse)
    );

endmodule
